FILE: rtl/ffba_pkg.sv
`default_nettype none

package ffba_pkg;

    // Table geometry
    localparam int MAX_BLOCKS = 64;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int ACC_W      = SIZE_BITS + CNT_W;

    // Port field widths
    localparam int SIZE_IN_W  = 16;
    localparam int INDEX_W    = 6;
    localparam int REM_W      = 16;
    localparam int FRAG_W     = 22;

    // Item kinds
    typedef enum logic [1:0] {
        K_CLEAR  = 2'd0,
        K_LOAD   = 2'd1,
        K_ALLOC  = 2'd2,
        K_REPORT = 2'd3
    } kind_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    // Sequencer to shared unit
    typedef struct packed {
        logic clr;
        logic acc;
    } unit_ctrl_t;

    // Shared unit to sequencer
    typedef struct packed {
        logic                 fits;
        logic [SIZE_BITS-1:0] diff;
        logic [ACC_W-1:0]     internal_sum;
        logic [ACC_W-1:0]     untouched_sum;
    } unit_stat_t;

endpackage

`default_nettype wire

FILE: rtl/ffba_table.sv
`default_nettype none

module ffba_table
    import ffba_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 wr_orig,
    input  wire logic                 wr_rem,
    input  wire logic [IDX_W-1:0]     wr_addr,
    input  wire logic [SIZE_BITS-1:0] wr_orig_data,
    input  wire logic [SIZE_BITS-1:0] wr_rem_data,
    input  wire logic [IDX_W-1:0]     rd_addr,
    output logic      [SIZE_BITS-1:0] rd_orig,
    output logic      [SIZE_BITS-1:0] rd_rem
);

    logic [SIZE_BITS-1:0] orig_mem [MAX_BLOCKS];
    logic [SIZE_BITS-1:0] rem_mem  [MAX_BLOCKS];

    // Loaded sizes: written on load only
    always_ff @(posedge clk)
    begin
        if (wr_orig)
        begin
            orig_mem[wr_addr] <= wr_orig_data;
        end
        rd_orig <= orig_mem[rd_addr];
    end

    // Remaining sizes: written on load and on a placed request
    always_ff @(posedge clk)
    begin
        if (wr_rem)
        begin
            rem_mem[wr_addr] <= wr_rem_data;
        end
        rd_rem <= rem_mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/ffba_unit.sv
`default_nettype none

module ffba_unit
    import ffba_pkg::*;
(
    input  wire logic                 clk,
    input  wire unit_ctrl_t           ctrl,
    input  wire logic [SIZE_BITS-1:0] req_size,
    input  wire logic [SIZE_BITS-1:0] rd_orig,
    input  wire logic [SIZE_BITS-1:0] rd_rem,
    output unit_stat_t                stat
);

    logic [ACC_W-1:0] internal_reg;
    logic [ACC_W-1:0] untouched_reg;

    // Fit check and subtract on the entry being scanned
    always_comb
    begin
        stat.fits          = (req_size <= rd_rem);
        stat.diff          = rd_rem - req_size;
        stat.internal_sum  = internal_reg;
        stat.untouched_sum = untouched_reg;
    end

    // Fragmentation accumulators
    always_ff @(posedge clk)
    begin
        if (ctrl.clr)
        begin
            internal_reg  <= '0;
            untouched_reg <= '0;
        end
        else if (ctrl.acc)
        begin
            if (rd_rem != rd_orig)
            begin
                internal_reg <= internal_reg + ACC_W'(rd_rem);
            end
            else
            begin
                untouched_reg <= untouched_reg + ACC_W'(rd_rem);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/first_fit_block_allocator.sv
`default_nettype none

// Channel  Handshake             Payload
// input    in_valid / in_stall   kind, size_value
// output   out_valid / out_stall result_kind, placed, block_index, remaining_after,
//                                table_full_error, internal_frag, external_frag
//
// Clear and load go from accept to the done state and then to the output
// register. Allocate and report scan k entries on the way, k at most the
// block count: one table entry per cycle through a single memory read port.
// Reset empties the table; entries are defined only once loaded.
// A new item is taken while the last result waits; its result is held
// until the output register frees up.

module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           kind,
    input  wire logic [SIZE_IN_W-1:0] size_value,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic      [1:0]           result_kind,
    output logic                      placed,
    output logic      [INDEX_W-1:0]   block_index,
    output logic      [REM_W-1:0]     remaining_after,
    output logic                      table_full_error,
    output logic      [FRAG_W-1:0]    internal_frag,
    output logic      [FRAG_W-1:0]    external_frag
);

    state_t               state_reg, state_next;
    kind_t                kind_reg, kind_next;
    logic [SIZE_BITS-1:0] sz_reg, sz_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 any_reg, any_next;
    logic [SIZE_BITS-1:0] min_reg, min_next;

    logic                 res_placed_reg, res_placed_next;
    logic [INDEX_W-1:0]   res_idx_reg, res_idx_next;
    logic [REM_W-1:0]     res_rem_reg, res_rem_next;
    logic                 res_err_reg, res_err_next;

    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           out_kind_reg, out_kind_next;
    logic                 out_placed_reg, out_placed_next;
    logic [INDEX_W-1:0]   out_idx_reg, out_idx_next;
    logic [REM_W-1:0]     out_rem_reg, out_rem_next;
    logic                 out_err_reg, out_err_next;
    logic [FRAG_W-1:0]    out_int_reg, out_int_next;
    logic [FRAG_W-1:0]    out_ext_reg, out_ext_next;

    logic                 in_accept;
    kind_t                kind_in;
    logic [SIZE_BITS-1:0] sz_in;
    logic [CNT_W-1:0]     idx_inc;
    logic                 last;
    logic                 full;
    logic                 ext_hit;

    logic                 wr_orig;
    logic                 wr_rem;
    logic [IDX_W-1:0]     wr_addr;
    logic [SIZE_BITS-1:0] wr_rem_data;
    logic [IDX_W-1:0]     rd_addr;
    logic [SIZE_BITS-1:0] rd_orig;
    logic [SIZE_BITS-1:0] rd_rem;
    unit_ctrl_t           ctrl;
    unit_stat_t           stat;

    ffba_table u_table (
        .clk          (clk),
        .wr_orig      (wr_orig),
        .wr_rem       (wr_rem),
        .wr_addr      (wr_addr),
        .wr_orig_data (sz_in),
        .wr_rem_data  (wr_rem_data),
        .rd_addr      (rd_addr),
        .rd_orig      (rd_orig),
        .rd_rem       (rd_rem)
    );

    ffba_unit u_unit (
        .clk      (clk),
        .ctrl     (ctrl),
        .req_size (sz_reg),
        .rd_orig  (rd_orig),
        .rd_rem   (rd_rem),
        .stat     (stat)
    );

    // Handshake and helpers
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign kind_in   = kind_t'(kind);
    assign sz_in     = SIZE_BITS'(size_value);
    assign idx_inc   = CNT_W'(idx_reg) + CNT_W'(1);
    assign last      = (idx_inc == count_reg);
    assign full      = (count_reg == CNT_W'(MAX_BLOCKS));
    assign ext_hit   = any_reg && (ACC_W'(min_reg) <= stat.untouched_sum);

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        sz_next         = sz_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        any_next        = any_reg;
        min_next        = min_reg;
        res_placed_next = res_placed_reg;
        res_idx_next    = res_idx_reg;
        res_rem_next    = res_rem_reg;
        res_err_next    = res_err_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_kind_next   = out_kind_reg;
        out_placed_next = out_placed_reg;
        out_idx_next    = out_idx_reg;
        out_rem_next    = out_rem_reg;
        out_err_next    = out_err_reg;
        out_int_next    = out_int_reg;
        out_ext_next    = out_ext_reg;
        ctrl            = '0;
        wr_orig         = 1'b0;
        wr_rem          = 1'b0;
        wr_addr         = count_reg[IDX_W-1:0];
        wr_rem_data     = sz_in;
        rd_addr         = idx_inc[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = '0;
                if (in_accept)
                begin
                    kind_next       = kind_in;
                    sz_next         = sz_in;
                    idx_next        = '0;
                    res_placed_next = 1'b0;
                    res_idx_next    = '0;
                    res_rem_next    = '0;
                    res_err_next    = 1'b0;
                    ctrl.clr        = 1'b1;
                    state_next      = S_DONE;
                    unique case (kind_in)
                        K_CLEAR:
                        begin
                            count_next = '0;
                            any_next   = 1'b0;
                            min_next   = '1;
                        end
                        K_LOAD:
                        begin
                            if (full)
                            begin
                                res_err_next = 1'b1;
                            end
                            else
                            begin
                                wr_orig      = 1'b1;
                                wr_rem       = 1'b1;
                                res_idx_next = INDEX_W'(count_reg);
                                count_next   = count_reg + CNT_W'(1);
                            end
                        end
                        K_ALLOC:
                        begin
                            if (count_reg == '0)
                            begin
                                // nothing to scan: record as unplaced
                                if (!any_reg || (sz_in < min_reg))
                                begin
                                    min_next = sz_in;
                                end
                                any_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        K_REPORT:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                unique case (kind_reg)
                    K_ALLOC:
                    begin
                        if (stat.fits)
                        begin
                            wr_rem          = 1'b1;
                            wr_addr         = idx_reg;
                            wr_rem_data     = stat.diff;
                            res_placed_next = 1'b1;
                            res_idx_next    = INDEX_W'(idx_reg);
                            res_rem_next    = REM_W'(stat.diff);
                            state_next      = S_DONE;
                        end
                        else if (last)
                        begin
                            if (!any_reg || (sz_reg < min_reg))
                            begin
                                min_next = sz_reg;
                            end
                            any_next   = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            idx_next = idx_inc[IDX_W-1:0];
                        end
                    end
                    K_REPORT:
                    begin
                        ctrl.acc = 1'b1;
                        if (last)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            idx_next = idx_inc[IDX_W-1:0];
                        end
                    end
                    K_CLEAR, K_LOAD:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_DONE:
            begin
                // hand the result over once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = kind_reg;
                    out_placed_next = res_placed_reg;
                    out_idx_next    = res_idx_reg;
                    out_rem_next    = res_rem_reg;
                    out_err_next    = res_err_reg;
                    out_int_next    = '0;
                    out_ext_next    = '0;
                    if (kind_reg == K_REPORT)
                    begin
                        out_int_next = FRAG_W'(stat.internal_sum);
                        if (ext_hit)
                        begin
                            out_ext_next = FRAG_W'(stat.untouched_sum);
                        end
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            any_reg       <= 1'b0;
            min_reg       <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            any_reg       <= any_next;
            min_reg       <= min_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        sz_reg         <= sz_next;
        idx_reg        <= idx_next;
        res_placed_reg <= res_placed_next;
        res_idx_reg    <= res_idx_next;
        res_rem_reg    <= res_rem_next;
        res_err_reg    <= res_err_next;
        out_kind_reg   <= out_kind_next;
        out_placed_reg <= out_placed_next;
        out_idx_reg    <= out_idx_next;
        out_rem_reg    <= out_rem_next;
        out_err_reg    <= out_err_next;
        out_int_reg    <= out_int_next;
        out_ext_reg    <= out_ext_next;
    end

    // Outputs
    assign out_valid        = out_valid_reg;
    assign result_kind      = out_kind_reg;
    assign placed           = out_placed_reg;
    assign block_index      = out_idx_reg;
    assign remaining_after  = out_rem_reg;
    assign table_full_error = out_err_reg;
    assign internal_frag    = out_int_reg;
    assign external_frag    = out_ext_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count above table size");

    a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CNT_W'(idx_reg) < count_reg))
        else $error("scan index beyond loaded blocks");

    a_placed_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && placed) |-> (result_kind == K_ALLOC))
        else $error("placed flag on a non-allocate result");

    a_scan_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |=> (state_reg == S_SCAN) || (state_reg == S_DONE))
        else $error("scan left without passing through done");

endmodule

`default_nettype wire
